/* rtl/core/ordered_record_list_assert.svh */
// ----------------------------------------------------------------------------
// Ordered record list assertion macros
// Concurrent assertion shorthands used by the list top level. They drop out when
// SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ORDERED_RECORD_LIST_ASSERT_SVH
`define ORDERED_RECORD_LIST_ASSERT_SVH

`ifndef SYNTH

// Consequent must hold in the same cycle as the antecedent.
`define ORL_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ordered_record_list: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ORL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ordered_record_list: next-cycle check failed");

`else

`define ORL_ASSERT_SAME(label, clk, rst, ante, cons)
`define ORL_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/core/orl_pkg.sv */
// ----------------------------------------------------------------------------
// Ordered record list package
// Sizes, operation and status codes, transfer structs and the name
// normalization function shared by the list modules.
// ----------------------------------------------------------------------------
package orl_pkg;

  // Number of records the list can hold.
  localparam int CAPACITY = 128;

  // Record memory address width and list length width.
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int LEN_W  = $clog2(CAPACITY + 1);

  // Width used to compare positions against the length without overflow.
  localparam int CMP_W = ((LEN_W > 8) ? LEN_W : 8) + 1;

  // Operation codes.
  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_APPEND = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_READ   = 3'd3;
  localparam logic [2:0] OP_FIND   = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INVALID   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // One request transfer.
  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  position;
    logic [63:0] key_first_bytes;
    logic [7:0]  key_last_byte;
    logic [15:0] new_age;
  } req_t;

  // One result transfer.
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  current_length;
    logic [7:0]  found_index;
    logic [63:0] read_first_bytes;
    logic [7:0]  read_last_byte;
    logic [15:0] read_age;
  } rsp_t;

  // One stored record.
  typedef struct packed {
    logic [63:0] name_first;
    logic [7:0]  name_last;
    logic [15:0] age;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // Record memory access: write port and read address.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    rec_t              wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // Clear every name character after the first zero character.
  function automatic rec_t normalize(input logic [63:0] first, input logic [7:0] last,
                                     input logic [15:0] age);
    rec_t r;
    logic ended;
    ended = 1'b0;
    r.name_first = '0;
    for (int b = 0; b < 8; b++) begin
      if (first[8*b +: 8] == 8'd0) begin
        ended = 1'b1;
      end
      if (!ended) begin
        r.name_first[8*b +: 8] = first[8*b +: 8];
      end
    end
    r.name_last = ended ? 8'd0 : last;
    r.age = age;
    return r;
  endfunction

endpackage

/* rtl/core/orl_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered, so it appears
// in the cycle after the address.
// ----------------------------------------------------------------------------
module orl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/orl_ctrl.sv */
// ----------------------------------------------------------------------------
// Ordered record list controller
// Decodes requests, walks the record memory to shift or search, and builds
// the one-cycle result transfer.
// ----------------------------------------------------------------------------
module orl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  orl_pkg::req_t     request,
  output logic              done,
  output orl_pkg::rsp_t     result,
  output orl_pkg::mem_req_t mem_req,
  input  orl_pkg::rec_t     mem_rdata
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MOVE   = 3'd1;
  localparam logic [2:0] S_INS_WR = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_RDATA  = 3'd4;
  localparam logic [2:0] S_FIND   = 3'd5;

  logic [2:0]                 state;
  logic [2:0]                 op;
  orl_pkg::rec_t              new_rec;
  logic [orl_pkg::ADDR_W-1:0] pos_a;
  logic [orl_pkg::LEN_W-1:0]  len;
  logic [orl_pkg::ADDR_W-1:0] cnt;
  logic [orl_pkg::ADDR_W-1:0] stop;
  logic                       issuing;
  logic                       pend;
  logic [orl_pkg::ADDR_W-1:0] pend_dst;

  logic [orl_pkg::CMP_W-1:0]  pos_cw;
  logic [orl_pkg::CMP_W-1:0]  len_cw;
  logic [orl_pkg::CMP_W-1:0]  pos_m1;
  logic [orl_pkg::CMP_W-1:0]  len_m1;
  logic [orl_pkg::CMP_W-1:0]  found_cw;
  logic                       full;
  logic                       bad_ins;
  logic                       bad_pos;
  logic                       down;
  logic                       name_hit;
  orl_pkg::rec_t              key_rec;

  // Pack one result transfer; only a read carries record data.
  function automatic orl_pkg::rsp_t make_rsp(input logic [1:0] st,
                                             input logic [orl_pkg::LEN_W-1:0] l,
                                             input logic [orl_pkg::CMP_W-1:0] f,
                                             input orl_pkg::rec_t rec);
    orl_pkg::rsp_t r;
    logic [orl_pkg::CMP_W-1:0] l_cw;
    l_cw = orl_pkg::CMP_W'(l);
    r.status           = st;
    r.current_length   = l_cw[7:0];
    r.found_index      = f[7:0];
    r.read_first_bytes = rec.name_first;
    r.read_last_byte   = rec.name_last;
    r.read_age         = rec.age;
    return r;
  endfunction

  // Request decode terms.
  always_comb begin
    key_rec  = orl_pkg::normalize(request.key_first_bytes, request.key_last_byte,
                                  request.new_age);
    pos_cw   = orl_pkg::CMP_W'(request.position);
    len_cw   = orl_pkg::CMP_W'(len);
    pos_m1   = pos_cw - orl_pkg::CMP_W'(1);
    len_m1   = len_cw - orl_pkg::CMP_W'(1);
    full     = len_cw >= orl_pkg::CMP_W'(orl_pkg::CAPACITY);
    bad_ins  = (pos_cw == '0) || (pos_cw > len_cw + orl_pkg::CMP_W'(1));
    bad_pos  = (pos_cw == '0) || (pos_cw > len_cw);
    down     = (op == orl_pkg::OP_INSERT);
    name_hit = (mem_rdata.name_first == new_rec.name_first) &&
               (mem_rdata.name_last == new_rec.name_last);
    found_cw = orl_pkg::CMP_W'(pend_dst) + orl_pkg::CMP_W'(1);
  end

  // Record memory access: reads follow the walk counter, writes land either
  // the shifted record or the new one.
  always_comb begin
    mem_req.raddr = cnt;
    mem_req.we    = ((state == S_MOVE) && pend) || (state == S_INS_WR);
    mem_req.waddr = (state == S_INS_WR) ? pos_a : pend_dst;
    mem_req.wdata = (state == S_INS_WR) ? new_rec : mem_rdata;
  end

  assign busy = (state != S_IDLE);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      len     <= '0;
      issuing <= 1'b0;
      pend    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op      <= request.opcode;
            new_rec <= key_rec;
            pos_a   <= pos_m1[orl_pkg::ADDR_W-1:0];
            pend    <= 1'b0;
            case (request.opcode)
              orl_pkg::OP_INSERT: begin
                if (full) begin
                  done   <= 1'b1;
                  result <= make_rsp(orl_pkg::ST_FULL, len, '0, '0);
                end else if (bad_ins) begin
                  done   <= 1'b1;
                  result <= make_rsp(orl_pkg::ST_INVALID, len, '0, '0);
                end else if (pos_cw == len_cw + orl_pkg::CMP_W'(1)) begin
                  state <= S_INS_WR;
                end else begin
                  state   <= S_MOVE;
                  cnt     <= len_m1[orl_pkg::ADDR_W-1:0];
                  stop    <= pos_m1[orl_pkg::ADDR_W-1:0];
                  issuing <= 1'b1;
                end
              end
              orl_pkg::OP_APPEND: begin
                if (full) begin
                  done   <= 1'b1;
                  result <= make_rsp(orl_pkg::ST_FULL, len, '0, '0);
                end else begin
                  pos_a <= len_cw[orl_pkg::ADDR_W-1:0];
                  state <= S_INS_WR;
                end
              end
              orl_pkg::OP_DELETE: begin
                if (bad_pos) begin
                  done   <= 1'b1;
                  result <= make_rsp(orl_pkg::ST_INVALID, len, '0, '0);
                end else if (pos_cw == len_cw) begin
                  len    <= len - orl_pkg::LEN_W'(1);
                  done   <= 1'b1;
                  result <= make_rsp(orl_pkg::ST_OK, len - orl_pkg::LEN_W'(1), '0, '0);
                end else begin
                  state   <= S_MOVE;
                  cnt     <= pos_cw[orl_pkg::ADDR_W-1:0];
                  stop    <= len_m1[orl_pkg::ADDR_W-1:0];
                  issuing <= 1'b1;
                end
              end
              orl_pkg::OP_READ: begin
                if (bad_pos) begin
                  done   <= 1'b1;
                  result <= make_rsp(orl_pkg::ST_INVALID, len, '0, '0);
                end else begin
                  cnt   <= pos_m1[orl_pkg::ADDR_W-1:0];
                  state <= S_READ;
                end
              end
              orl_pkg::OP_FIND: begin
                if (len == '0) begin
                  done   <= 1'b1;
                  result <= make_rsp(orl_pkg::ST_NOT_FOUND, len, '0, '0);
                end else begin
                  state   <= S_FIND;
                  cnt     <= '0;
                  stop    <= len_m1[orl_pkg::ADDR_W-1:0];
                  issuing <= 1'b1;
                end
              end
              default: begin
                done   <= 1'b1;
                result <= make_rsp(orl_pkg::ST_OK, len, '0, '0);
              end
            endcase
          end
        end

        // Shift walk: read one entry a cycle, write it one slot over in the
        // cycle after.
        S_MOVE: begin
          if (issuing) begin
            pend     <= 1'b1;
            pend_dst <= down ? cnt + orl_pkg::ADDR_W'(1) : cnt - orl_pkg::ADDR_W'(1);
            if (cnt == stop) begin
              issuing <= 1'b0;
            end else begin
              cnt <= down ? cnt - orl_pkg::ADDR_W'(1) : cnt + orl_pkg::ADDR_W'(1);
            end
          end else begin
            pend <= 1'b0;
            if (down) begin
              state <= S_INS_WR;
            end else begin
              len    <= len - orl_pkg::LEN_W'(1);
              done   <= 1'b1;
              result <= make_rsp(orl_pkg::ST_OK, len - orl_pkg::LEN_W'(1), '0, '0);
              state  <= S_IDLE;
            end
          end
        end

        // Store the new record and grow the list.
        S_INS_WR: begin
          len    <= len + orl_pkg::LEN_W'(1);
          done   <= 1'b1;
          result <= make_rsp(orl_pkg::ST_OK, len + orl_pkg::LEN_W'(1), '0, '0);
          state  <= S_IDLE;
        end

        S_READ: begin
          state <= S_RDATA;
        end

        S_RDATA: begin
          done   <= 1'b1;
          result <= make_rsp(orl_pkg::ST_OK, len, '0, mem_rdata);
          state  <= S_IDLE;
        end

        // Search walk: compare each record as its read data returns.
        S_FIND: begin
          if (issuing) begin
            pend     <= 1'b1;
            pend_dst <= cnt;
            if (cnt == stop) begin
              issuing <= 1'b0;
            end else begin
              cnt <= cnt + orl_pkg::ADDR_W'(1);
            end
          end
          if (pend) begin
            if (name_hit) begin
              done    <= 1'b1;
              result  <= make_rsp(orl_pkg::ST_OK, len, found_cw, '0);
              state   <= S_IDLE;
              issuing <= 1'b0;
              pend    <= 1'b0;
            end else if (!issuing) begin
              done   <= 1'b1;
              result <= make_rsp(orl_pkg::ST_NOT_FOUND, len, '0, '0);
              state  <= S_IDLE;
              pend   <= 1'b0;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/ordered_record_list.sv */
// ----------------------------------------------------------------------------
// Ordered record list
// Fixed-capacity ordered list of name and age records with insert, append,
// delete, read and find, held in one record memory.
//
//   Channel  | Handshake           | Payload
//   ---------+---------------------+-----------------
//   request  | start high, busy low| request (req_t)
//   result   | done, one cycle     | result (rsp_t)
//
// Errors, unused codes and a delete of the last record answer straight from idle;
// append and an insert at the end pass through the write state, read through the
// read address and read data states. Other inserts and deletes shift the records
// one per cycle through the record memory; find walks from the front to a match
// or the end, answering at once on an empty list. Reset empties the list at once;
// the result cannot be stalled and a new request is taken in the cycle it shows.
// ----------------------------------------------------------------------------
`include "ordered_record_list_assert.svh"

module ordered_record_list (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  orl_pkg::req_t request,
  output logic          done,
  output orl_pkg::rsp_t result
);

  orl_pkg::mem_req_t mem_req;
  orl_pkg::rec_t     mem_rdata;

  // Sequencing and result formation.
  orl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  // Record storage.
  orl_ram #(
    .WIDTH (orl_pkg::REC_W),
    .DEPTH (orl_pkg::CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // An accepted request either answers next cycle or keeps the block busy.
  `ORL_ASSERT_NEXT(a_accept_progress, clk, rst, start && !busy, busy || done)
  // A result is only shown once the sequencer is back at rest.
  `ORL_ASSERT_SAME(a_done_idle, clk, rst, done, !busy)
  // The record memory is never written while no request is in progress.
  `ORL_ASSERT_SAME(a_no_idle_write, clk, rst, !busy, !mem_req.we)
  // A failed find reports no index.
  `ORL_ASSERT_SAME(a_miss_index, clk, rst,
                   done && (result.status == orl_pkg::ST_NOT_FOUND),
                   result.found_index == 8'd0)

endmodule

/* bench/ordered_record_list_tb.sv */
// ----------------------------------------------------------------------------
// Ordered record list testbench
// Drives insert, append, delete, read and find requests into the list and
// checks every result against a local model of the record list or, in some
// scripted steps, a result written out by hand. A short scripted sequence covers
// the empty list, position bounds, extreme values, name trimming and unused codes.
// It is followed by random traffic that fills the list to capacity and drains it
// again. Requests go out in bursts with random gaps.
// ----------------------------------------------------------------------------
module ordered_record_list_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Unused operation codes; the list must ignore them.
  localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
  localparam logic [2:0] OP_RSVD_LAST  = 3'd7;

  localparam int SCRIPT_LEN   = 24;
  localparam int RANDOM_ITEMS = 1130;
  localparam int TAIL_CYCLES  = 150;
  localparam int POOL_SIZE    = 8;

  // Names used by the scripted sequence; character one sits in the low byte.
  localparam logic [63:0] ANN_FIRST      = 64'h0000_0000_006E_6E61;
  localparam logic [63:0] LONG_FIRST     = 64'h4847_4645_4443_4241;
  localparam logic [7:0]  LONG_LAST      = 8'h49;
  localparam logic [63:0] BOB_FIRST      = 64'h0000_0000_0062_6F62;
  localparam logic [63:0] BOB_JUNK_FIRST = 64'h6B6E_756A_0062_6F62;
  localparam logic [63:0] BOB_ALT_FIRST  = 64'h0000_7A79_0062_6F62;
  localparam logic [63:0] ONES64         = 64'hFFFF_FFFF_FFFF_FFFF;

  // One scripted request, with its result written out where it is obvious.
  typedef struct packed {
    orl_pkg::req_t req;
    logic          typed;
    orl_pkg::rsp_t want;
  } step_t;

  logic          clk;
  logic          rst;
  logic          start;
  logic          busy;
  orl_pkg::req_t request;
  logic          done;
  orl_pkg::rsp_t result;

  ordered_record_list dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  // Local copy of the list: names held as {ninth character, first eight}.
  logic [71:0] roster_name [orl_pkg::CAPACITY];
  logic [15:0] roster_age  [orl_pkg::CAPACITY];
  int          roster_len;

  orl_pkg::rsp_t pending_results [$];
  int            mismatches;
  int            burst_left;
  logic [71:0]   name_pool [POOL_SIZE];

  // Random traffic alternates between growing and shrinking the list.
  bit filling;
  int fill_target;
  int drain_target;
  int hold_full;

  step_t script [SCRIPT_LEN] = '{
    '{'{orl_pkg::OP_READ,   8'd1,   64'd0,     8'd0,      16'd0},      1'b1,
      '{orl_pkg::ST_INVALID,   8'd0, 8'd0, 64'd0, 8'd0, 16'd0}},
    '{'{orl_pkg::OP_DELETE, 8'd0,   64'd0,     8'd0,      16'd0},      1'b1,
      '{orl_pkg::ST_INVALID,   8'd0, 8'd0, 64'd0, 8'd0, 16'd0}},
    '{'{orl_pkg::OP_FIND,   8'd0,   ANN_FIRST, 8'd0,      16'd0},      1'b1,
      '{orl_pkg::ST_NOT_FOUND, 8'd0, 8'd0, 64'd0, 8'd0, 16'd0}},
    '{'{orl_pkg::OP_INSERT, 8'd2,   ANN_FIRST, 8'd0,      16'd5},      1'b1,
      '{orl_pkg::ST_INVALID,   8'd0, 8'd0, 64'd0, 8'd0, 16'd0}},
    '{'{orl_pkg::OP_INSERT, 8'd0,   ANN_FIRST, 8'd0,      16'd5},      1'b1,
      '{orl_pkg::ST_INVALID,   8'd0, 8'd0, 64'd0, 8'd0, 16'd0}},
    '{'{orl_pkg::OP_INSERT, 8'd1,   ANN_FIRST, 8'd0,      16'd0},      1'b1,
      '{orl_pkg::ST_OK,        8'd1, 8'd0, 64'd0, 8'd0, 16'd0}},
    '{'{orl_pkg::OP_APPEND, 8'd0,   ONES64,    8'hFF,     16'hFFFF},   1'b1,
      '{orl_pkg::ST_OK,        8'd2, 8'd0, 64'd0, 8'd0, 16'd0}},
    '{'{orl_pkg::OP_READ,   8'd2,   64'd0,     8'd0,      16'd0},      1'b1,
      '{orl_pkg::ST_OK,        8'd2, 8'd0, ONES64, 8'hFF, 16'hFFFF}},
    '{'{orl_pkg::OP_INSERT, 8'd3,   BOB_JUNK_FIRST, 8'hAA, 16'h1234},  1'b0, '0},
    '{'{orl_pkg::OP_INSERT, 8'd1,   LONG_FIRST, LONG_LAST, 16'd7},     1'b0, '0},
    '{'{orl_pkg::OP_APPEND, 8'd0,   64'd0,     8'h55,     16'h8001},   1'b0, '0},
    '{'{orl_pkg::OP_FIND,   8'd0,   BOB_FIRST, 8'd0,      16'd0},      1'b0, '0},
    '{'{orl_pkg::OP_FIND,   8'd0,   BOB_ALT_FIRST, 8'h33, 16'd0},      1'b0, '0},
    '{'{orl_pkg::OP_READ,   8'd255, 64'd0,     8'd0,      16'd0},      1'b1,
      '{orl_pkg::ST_INVALID,   8'd5, 8'd0, 64'd0, 8'd0, 16'd0}},
    '{'{orl_pkg::OP_READ,   8'd6,   64'd0,     8'd0,      16'd0},      1'b1,
      '{orl_pkg::ST_INVALID,   8'd5, 8'd0, 64'd0, 8'd0, 16'd0}},
    '{'{orl_pkg::OP_DELETE, 8'd6,   64'd0,     8'd0,      16'd0},      1'b1,
      '{orl_pkg::ST_INVALID,   8'd5, 8'd0, 64'd0, 8'd0, 16'd0}},
    '{'{orl_pkg::OP_INSERT, 8'd7,   ANN_FIRST, 8'd0,      16'd9},      1'b1,
      '{orl_pkg::ST_INVALID,   8'd5, 8'd0, 64'd0, 8'd0, 16'd0}},
    '{'{OP_RSVD_FIRST, 8'd1, ANN_FIRST, 8'd0,    16'd3},      1'b1,
      '{orl_pkg::ST_OK,        8'd5, 8'd0, 64'd0, 8'd0, 16'd0}},
    '{'{OP_RSVD_LAST, 8'd255, ONES64, 8'hFF,     16'hFFFF},   1'b1,
      '{orl_pkg::ST_OK,        8'd5, 8'd0, 64'd0, 8'd0, 16'd0}},
    '{'{orl_pkg::OP_FIND,   8'd0,   64'd0,     8'h77,     16'd0},      1'b0, '0},
    '{'{orl_pkg::OP_FIND,   8'd0,   LONG_FIRST, 8'h4A,    16'd0},      1'b1,
      '{orl_pkg::ST_NOT_FOUND, 8'd5, 8'd0, 64'd0, 8'd0, 16'd0}},
    '{'{orl_pkg::OP_DELETE, 8'd1,   64'd0,     8'd0,      16'd0},      1'b0, '0},
    '{'{orl_pkg::OP_DELETE, 8'd4,   64'd0,     8'd0,      16'd0},      1'b0, '0},
    '{'{orl_pkg::OP_READ,   8'd1,   64'd0,     8'd0,      16'd0},      1'b0, '0}
  };

  // Clock generation.
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // A name ends at its first zero character; everything after it is cleared.
  function automatic logic [71:0] trim_name(logic [71:0] raw);
    logic [71:0] n;
    bit          cut;
    n = raw;
    cut = 1'b0;
    for (int b = 0; b < 9; b++) begin
      if (n[8*b +: 8] == 8'd0) cut = 1'b1;
      if (cut) n[8*b +: 8] = 8'd0;
    end
    return n;
  endfunction

  // Applies one request to the local list and returns the expected result.
  function automatic orl_pkg::rsp_t apply_request(orl_pkg::req_t r);
    orl_pkg::rsp_t res;
    logic [71:0]   key;
    int            pos;
    res = '0;
    key = trim_name({r.key_last_byte, r.key_first_bytes});
    pos = r.position;
    case (r.opcode)
      orl_pkg::OP_INSERT: begin
        if (roster_len >= orl_pkg::CAPACITY) begin
          res.status = orl_pkg::ST_FULL;
        end else if (pos < 1 || pos > roster_len + 1) begin
          res.status = orl_pkg::ST_INVALID;
        end else begin
          for (int i = roster_len; i >= pos; i--) begin
            roster_name[i] = roster_name[i-1];
            roster_age[i]  = roster_age[i-1];
          end
          roster_name[pos-1] = key;
          roster_age[pos-1]  = r.new_age;
          roster_len++;
        end
      end
      orl_pkg::OP_APPEND: begin
        if (roster_len >= orl_pkg::CAPACITY) begin
          res.status = orl_pkg::ST_FULL;
        end else begin
          roster_name[roster_len] = key;
          roster_age[roster_len]  = r.new_age;
          roster_len++;
        end
      end
      orl_pkg::OP_DELETE: begin
        if (pos < 1 || pos > roster_len) begin
          res.status = orl_pkg::ST_INVALID;
        end else begin
          for (int i = pos; i < roster_len; i++) begin
            roster_name[i-1] = roster_name[i];
            roster_age[i-1]  = roster_age[i];
          end
          roster_len--;
        end
      end
      orl_pkg::OP_READ: begin
        if (pos < 1 || pos > roster_len) begin
          res.status = orl_pkg::ST_INVALID;
        end else begin
          res.read_first_bytes = roster_name[pos-1][63:0];
          res.read_last_byte   = roster_name[pos-1][71:64];
          res.read_age         = roster_age[pos-1];
        end
      end
      orl_pkg::OP_FIND: begin
        res.status = orl_pkg::ST_NOT_FOUND;
        for (int i = 0; i < roster_len; i++) begin
          if (roster_name[i] == key) begin
            res.status = orl_pkg::ST_OK;
            res.found_index = 8'(i + 1);
            break;
          end
        end
      end
      default: begin
      end
    endcase
    res.current_length = 8'(roster_len);
    return res;
  endfunction

  // Fills every byte after the terminating zero with random characters.
  function automatic logic [71:0] add_junk(logic [71:0] n);
    logic [71:0] m;
    int          z;
    m = n;
    z = 9;
    for (int b = 8; b >= 0; b--) begin
      if (m[8*b +: 8] == 8'd0) z = b;
    end
    for (int b = z + 1; b < 9; b++) begin
      m[8*b +: 8] = 8'($urandom);
    end
    return m;
  endfunction

  // A clean name of random length, zero to nine characters.
  function automatic logic [71:0] fresh_name();
    logic [71:0] n;
    int          len;
    n = '0;
    len = $urandom_range(0, 9);
    for (int b = 0; b < len; b++) begin
      n[8*b +: 8] = 8'($urandom_range(1, 255));
    end
    return n;
  endfunction

  // Key for insert, append or a miss-prone find: shared, fresh or raw bits.
  function automatic logic [71:0] pick_name();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return {8'($urandom), $urandom, $urandom};
    if (roll < 50) return add_junk(name_pool[$urandom_range(0, POOL_SIZE - 1)]);
    if (roll < 75) return add_junk(fresh_name());
    return fresh_name();
  endfunction

  // Builds one random request, steering the list between full and empty.
  function automatic orl_pkg::req_t next_random_request();
    orl_pkg::req_t r;
    logic [71:0]   name;
    int            roll;
    if (filling && roster_len >= fill_target) begin
      if (hold_full > 0) begin
        hold_full--;
      end else begin
        filling = 1'b0;
        drain_target = $urandom_range(0, 1) ? 0 : $urandom_range(0, 20);
      end
    end else if (!filling && roster_len <= drain_target) begin
      filling = 1'b1;
      fill_target = ($urandom_range(0, 2) != 0) ? orl_pkg::CAPACITY
                                                : $urandom_range(20, 100);
      hold_full = 14;
    end

    roll = $urandom_range(0, 99);
    if (filling) begin
      if (roll < 30)      r.opcode = orl_pkg::OP_INSERT;
      else if (roll < 60) r.opcode = orl_pkg::OP_APPEND;
      else if (roll < 70) r.opcode = orl_pkg::OP_DELETE;
      else if (roll < 83) r.opcode = orl_pkg::OP_READ;
      else if (roll < 97) r.opcode = orl_pkg::OP_FIND;
      else                r.opcode = 3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
    end else begin
      if (roll < 8)       r.opcode = orl_pkg::OP_INSERT;
      else if (roll < 15) r.opcode = orl_pkg::OP_APPEND;
      else if (roll < 65) r.opcode = orl_pkg::OP_DELETE;
      else if (roll < 80) r.opcode = orl_pkg::OP_READ;
      else if (roll < 97) r.opcode = orl_pkg::OP_FIND;
      else                r.opcode = 3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
    end

    // Positions are mostly in range; the rest span the whole field.
    r.position = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 88) begin
      if (r.opcode == orl_pkg::OP_INSERT) begin
        r.position = 8'($urandom_range(1, roster_len + 1));
      end else if ((r.opcode == orl_pkg::OP_DELETE || r.opcode == orl_pkg::OP_READ) &&
                   roster_len > 0) begin
        r.position = 8'($urandom_range(1, roster_len));
      end
    end

    // Find keys usually name a stored record, with noise after the end.
    if (r.opcode == orl_pkg::OP_FIND && roster_len > 0 && $urandom_range(0, 99) < 55) begin
      name = add_junk(roster_name[$urandom_range(0, roster_len - 1)]);
    end else if (r.opcode == orl_pkg::OP_INSERT || r.opcode == orl_pkg::OP_APPEND ||
                 r.opcode == orl_pkg::OP_FIND) begin
      name = pick_name();
    end else begin
      name = {8'($urandom), $urandom, $urandom};
    end
    r.key_first_bytes = name[63:0];
    r.key_last_byte   = name[71:64];

    roll = $urandom_range(0, 99);
    if (roll < 4)      r.new_age = 16'h0000;
    else if (roll < 8) r.new_age = 16'hFFFF;
    else               r.new_age = 16'($urandom);
    return r;
  endfunction

  // Prints one mismatch line and counts it; printing stops after forty mismatches.
  task automatic report(string msg);
    if (mismatches < 40) $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Hands one request over, records its expected result, then maybe pauses.
  task automatic transfer_request(orl_pkg::req_t r, logic typed, orl_pkg::rsp_t want);
    orl_pkg::rsp_t predicted;
    logic [127:0]  noise;
    start   <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    predicted = apply_request(r);
    pending_results.push_back(typed ? want : predicted);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      noise = {$urandom, $urandom, $urandom, $urandom};
      start   <= 1'b0;
      request <= noise[$bits(orl_pkg::req_t)-1:0];
      repeat ($urandom_range(1, 9)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 8);
    end
  endtask

  // Result checking: each transfer is matched with the oldest expectation.
  always @(posedge clk) begin
    orl_pkg::rsp_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report("result with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        if (result.status !== want.status)
          report($sformatf("status %0d, expected %0d", result.status, want.status));
        if (result.current_length !== want.current_length)
          report($sformatf("current_length %0d, expected %0d",
                           result.current_length, want.current_length));
        if (result.found_index !== want.found_index)
          report($sformatf("found_index %0d, expected %0d",
                           result.found_index, want.found_index));
        if (result.read_first_bytes !== want.read_first_bytes)
          report($sformatf("read_first_bytes %h, expected %h",
                           result.read_first_bytes, want.read_first_bytes));
        if (result.read_last_byte !== want.read_last_byte)
          report($sformatf("read_last_byte %h, expected %h",
                           result.read_last_byte, want.read_last_byte));
        if (result.read_age !== want.read_age)
          report($sformatf("read_age %h, expected %h", result.read_age, want.read_age));
      end
    end
  end

  // Main sequence: reset, scripted requests, random traffic, drain.
  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    request    = '0;
    mismatches = 0;
    roster_len = 0;
    burst_left = 0;
    filling    = 1'b1;
    fill_target  = orl_pkg::CAPACITY;
    drain_target = 0;
    hold_full    = 14;
    for (int i = 0; i < orl_pkg::CAPACITY; i++) begin
      roster_name[i] = '0;
      roster_age[i]  = '0;
    end
    for (int i = 0; i < POOL_SIZE; i++) begin
      name_pool[i] = fresh_name();
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      transfer_request(script[i].req, script[i].typed, script[i].want);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      transfer_request(next_random_request(), 1'b0, '0);
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Run limit, well above the slowest legal run.
  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
